### hw/rtl/ads_pkg.sv
package ads_pkg;

  localparam int unsigned VALUE_BITS = 32;

  localparam logic OP_WRITE = 1'b1;

  localparam logic [VALUE_BITS-1:0] READ_MISS = '1;

  typedef struct packed {
    logic vld;
    logic wr;
    logic hit;
    logic alloc;
  } tok_ctrl_t;

endpackage

### hw/rtl/ads_cell.sv
module ads_cell import ads_pkg::*; #(
  parameter int unsigned ADDR_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  tok_ctrl_t             tok_i,
  input  logic [ADDR_BITS-1:0]  key_i,
  input  logic [VALUE_BITS-1:0] value_i,
  input  logic [VALUE_BITS-1:0] rdata_i,
  output tok_ctrl_t             tok_o,
  output logic [ADDR_BITS-1:0]  key_o,
  output logic [VALUE_BITS-1:0] value_o,
  output logic [VALUE_BITS-1:0] rdata_o,
  output logic                  valid_o
);

  logic                  valid_q;
  logic [ADDR_BITS-1:0]  key_q;
  logic [VALUE_BITS-1:0] value_q;

  tok_ctrl_t             tok_d, tok_q;
  logic [ADDR_BITS-1:0]  tkey_q;
  logic [VALUE_BITS-1:0] tvalue_q;
  logic [VALUE_BITS-1:0] rdata_d, rdata_q;

  logic match;
  logic claim;

  // valid entries always form a prefix, so the first free cell ends the search
  assign match = tok_i.vld && valid_q && (key_q == key_i);
  assign claim = tok_i.vld && tok_i.wr && !valid_q && !tok_i.hit && !tok_i.alloc;

  always_comb begin
    tok_d       = tok_i;
    tok_d.hit   = tok_i.hit | match;
    tok_d.alloc = tok_i.alloc | claim;
    rdata_d     = (match && !tok_i.wr) ? value_q : rdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      tok_q   <= '0;
    end else begin
      tok_q <= tok_d;
      if (claim) begin
        valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    tkey_q   <= key_i;
    tvalue_q <= value_i;
    rdata_q  <= rdata_d;
    if (claim) begin
      key_q   <= key_i;
      value_q <= value_i;
    end else if (match && tok_i.wr) begin
      value_q <= value_i;
    end
  end

  assign tok_o   = tok_q;
  assign key_o   = tkey_q;
  assign value_o = tvalue_q;
  assign rdata_o = rdata_q;
  assign valid_o = valid_q;

endmodule

### hw/rtl/associative_data_store.sv
// Associative data store: ENTRIES address/value pairs held in a row of cells.
// A transaction is taken when start_i is high and busy_o low; it then walks
// the row one cell per cycle, so its result appears on the result ports,
// marked by result_valid_o for one cycle, once it leaves the last cell, and
// busy_o drops in the cycle after, so a new transaction cannot be taken until
// the last is through, at a pace set by the length of the cell row. A read
// returns the stored value with hit_o, or -1 on a miss. A write updates a
// matching entry or claims the lowest free one; with no free entry it is
// dropped and full_res_o is raised. The result is never held, so it must be
// taken in the cycle it is shown. Reset frees every entry at once.
module associative_data_store import ads_pkg::*; #(
  parameter int unsigned ENTRIES   = 64,
  parameter int unsigned ADDR_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic                         operation_i,
  input  logic [ADDR_BITS-1:0]         address_i,
  input  logic signed [VALUE_BITS-1:0] write_value_i,
  output logic                         result_valid_o,
  output logic                         hit_o,
  output logic signed [VALUE_BITS-1:0] read_value_o,
  output logic                         full_res_o
);

  tok_ctrl_t             tok   [ENTRIES+1];
  logic [ADDR_BITS-1:0]  key   [ENTRIES+1];
  logic [VALUE_BITS-1:0] value [ENTRIES+1];
  logic [VALUE_BITS-1:0] rdata [ENTRIES+1];
  logic [ENTRIES-1:0]    valid_vec;

  logic      accept;
  logic      busy_d, busy_q;
  tok_ctrl_t last;

  assign accept = start_i && !busy_q;

  assign tok[0]   = '{vld: accept, wr: (operation_i == OP_WRITE), hit: 1'b0, alloc: 1'b0};
  assign key[0]   = address_i;
  assign value[0] = write_value_i;
  assign rdata[0] = '0;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    ads_cell #(
      .ADDR_BITS (ADDR_BITS)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .tok_i   (tok[i]),
      .key_i   (key[i]),
      .value_i (value[i]),
      .rdata_i (rdata[i]),
      .tok_o   (tok[i+1]),
      .key_o   (key[i+1]),
      .value_o (value[i+1]),
      .rdata_o (rdata[i+1]),
      .valid_o (valid_vec[i])
    );
  end

  assign last = tok[ENTRIES];

  always_comb begin
    busy_d = busy_q;
    if (accept) begin
      busy_d = 1'b1;
    end else if (last.vld) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  assign busy_o         = busy_q;
  assign result_valid_o = last.vld;
  assign hit_o          = last.hit;
  assign full_res_o     = last.wr && !last.hit && !last.alloc;

  always_comb begin
    if (last.wr) begin
      read_value_o = '0;
    end else if (last.hit) begin
      read_value_o = rdata[ENTRIES];
    end else begin
      read_value_o = READ_MISS;
    end
  end

  // key and value of the chain tail are not needed
  logic unused_tail;
  assign unused_tail = ^{key[ENTRIES], value[ENTRIES]};

  a_result_in_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy_q)
    else $error("result outside a transaction");

  a_hit_not_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !(hit_o && full_res_o))
    else $error("hit and full together");

  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_q && !result_valid_o)
    else $error("busy not raised after accept");

  a_valid_prefix : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_vec & (valid_vec + ENTRIES'(1))) == '0)
    else $error("valid entries not contiguous from zero");

endmodule
